// ===== sv/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types, constants and the level step function of the battery level
// monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

    localparam int SAMPLE_W    = 14;
    localparam int DUTY_W      = 7;
    localparam int CFG_W       = 7;
    localparam int TIMER_W     = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int RESULT_W    = 20;
    localparam int QUEUE_DEPTH = 2;

    localparam int WIN_MIN       = 3;
    localparam int PERIOD_MIN    = 4;
    localparam int STROBE_ON_END = 4;
    localparam int DUTY_ALERT    = 75;

    localparam logic [SAMPLE_W-1:0] MV_PLENTY_DOWN = 14'd3700;
    localparam logic [SAMPLE_W-1:0] MV_MID_UP      = 14'd3900;
    localparam logic [SAMPLE_W-1:0] MV_MID_DOWN    = 14'd3200;
    localparam logic [SAMPLE_W-1:0] MV_LOW_UP      = 14'd3500;
    localparam logic [SAMPLE_W-1:0] MV_LOW_DOWN    = 14'd2900;
    localparam logic [SAMPLE_W-1:0] MV_VLOW_UP     = 14'd3200;
    localparam logic [SAMPLE_W-1:0] MV_FAULT       = 14'd2700;
    localparam logic [SAMPLE_W-1:0] MV_MIN_RESET   = 14'h3FFF;

    localparam logic [0:0] REG_WINDOW_SAMPLES = 1'b0;
    localparam logic [0:0] REG_STROBE_PERIOD  = 1'b1;

    typedef enum logic [1:0] {
        LVL_PLENTY  = 2'd0,
        LVL_MID     = 2'd1,
        LVL_LOW     = 2'd2,
        LVL_VERYLOW = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_DIV    = 2'd2,
        ST_FINISH = 2'd3
    } core_state_t;

    typedef struct packed {
        logic [DUTY_W-1:0]   converter_duty;
        logic [SAMPLE_W-1:0] alert_threshold_mv;
        logic [SAMPLE_W-1:0] sample_mv;
    } item_t;

    typedef struct packed {
        logic                updated;
        logic                low_strobe;
        logic                alert;
        logic                fault;
        level_t              level;
        logic [SAMPLE_W-1:0] filtered_mv;
    } result_t;

    function automatic level_t next_level(input level_t lvl, input logic [SAMPLE_W-1:0] mv);
        level_t n;
        n = lvl;
        case (lvl)
            LVL_PLENTY:
            begin
                if (mv < MV_PLENTY_DOWN) n = LVL_MID;
            end
            LVL_MID:
            begin
                if (mv > MV_MID_UP) n = LVL_PLENTY;
                else if (mv < MV_MID_DOWN) n = LVL_LOW;
            end
            LVL_LOW:
            begin
                if (mv > MV_LOW_UP) n = LVL_MID;
                else if (mv < MV_LOW_DOWN) n = LVL_VERYLOW;
            end
            default:
            begin
                n = (mv > MV_VLOW_UP) ? LVL_LOW : LVL_VERYLOW;
            end
        endcase
        return n;
    endfunction

endpackage

// ===== sv/battery_level_monitor.sv =====
// ----------------------------------------------------------------------------
// battery_level_monitor
// Trimmed-mean battery voltage filter with hysteresis level detector, fault
// and alert flags and a very-low strobe.
// ----------------------------------------------------------------------------
// Every input request yields exactly one result request. A request that only
// adds to the window is written to the output register from ST_EXEC; the
// request that closes a window first goes through ST_DIV, where the trimmed
// running sum is fed through the one-bit-per-cycle restoring divider, and then
// ST_FINISH. SUM_W = 14 + clog2(MAX_WINDOW + 1) is the width of the sum. A
// two-entry input queue and the output register keep both sides moving
// while a result waits. Configuration writes are taken in any cycle.
module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sample_mv[13:0], alert_threshold_mv[27:14], converter_duty[34:28], zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // filtered_mv[13:0], level[15:14], fault[16], alert[17], low_strobe[18],
    // updated[19], zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [0:0]             cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [CFG_W-1:0] window_samples_reg;
    logic [CFG_W-1:0] strobe_period_reg;
    item_t            q_item;
    logic             q_valid;
    logic             q_pop;
    result_t          res;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {(OUT_TDATA_W - RESULT_W)'(0), res};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_samples_reg <= CFG_W'(8);
            strobe_period_reg  <= CFG_W'(16);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_SAMPLES: window_samples_reg <= cfg_data;
                REG_STROBE_PERIOD:  strobe_period_reg  <= cfg_data;
                default:            window_samples_reg <= window_samples_reg;
            endcase
        end
    end

    blm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_tdata[$bits(item_t)-1:0]),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    blm_core #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (q_valid),
        .item_pop       (q_pop),
        .item           (q_item),
        .window_samples (window_samples_reg),
        .strobe_period  (strobe_period_reg),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res            (res)
    );

endmodule

// ===== sv/blm_queue.sv =====
// ----------------------------------------------------------------------------
// blm_queue
// Front end: takes input requests and holds them in a short queue for the
// processing core.
// ----------------------------------------------------------------------------
module blm_queue
    import blm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_pop,
    output item_t out_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg < CNT_W'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== sv/blm_div.sv =====
// ----------------------------------------------------------------------------
// blm_div
// Restoring divider, one quotient bit per cycle. The quotient holds until
// the next start.
// ----------------------------------------------------------------------------
module blm_div
    import blm_pkg::*;
#(
    parameter int NW = 21,
    parameter int DW = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int STEP_W = $clog2(NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NW-1:0]     q_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     dvs_reg;
    logic [DW:0]       rem_sh;
    logic              ge;

    assign rem_sh   = {rem_reg, q_reg[NW-1]};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DW-1:0];
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

endmodule

// ===== sv/blm_core.sv =====
// ----------------------------------------------------------------------------
// blm_core
// Back end: windowed trimmed mean, level machine, fault and alert flags,
// strobe timer and the output register.
// ----------------------------------------------------------------------------
module blm_core
    import blm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_pop,
    input  item_t            item,
    input  logic [CFG_W-1:0] window_samples,
    input  logic [CFG_W-1:0] strobe_period,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    core_state_t         state_reg;
    core_state_t         state_next;
    item_t               cur_reg;
    logic                primed_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] fv_reg;
    level_t              level_reg;
    logic [TIMER_W-1:0]  timer_reg;
    result_t             res_reg;
    logic                res_valid_reg;

    logic                slot_free;
    logic                window_open;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_quot;
    logic                finish;
    logic                closing;
    logic [CMP_W-1:0]    win_cfg;
    logic [CMP_W-1:0]    win_use;
    logic [TIMER_W-1:0]  per_use;
    logic [TIMER_W-1:0]  timer_adv;
    logic [TIMER_W-1:0]  timer_next;
    logic [SAMPLE_W-1:0] fv_new;
    logic                upd_new;
    level_t              level_base;
    level_t              level_new;
    logic                fault_new;
    logic                alert_new;
    logic                strobe_new;

    assign slot_free   = !res_valid_reg || res_ready;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;
    assign win_cfg     = CMP_W'(window_samples);
    assign win_use     = (win_cfg < CMP_W'(WIN_MIN)) ? CMP_W'(WIN_MIN) :
                         (win_cfg > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : win_cfg;
    assign window_open = (CMP_W'(count_reg) < win_use);
    assign per_use     = (strobe_period < TIMER_W'(PERIOD_MIN)) ? TIMER_W'(PERIOD_MIN)
                                                                : strobe_period;

    blm_div #(
        .NW (SUM_W),
        .DW (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg)),
        .divisor  (count_reg - CNT_W'(2)),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        item_pop   = 1'b0;
        div_start  = 1'b0;
        finish     = 1'b0;
        closing    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (primed_reg && !window_open)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (slot_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done) state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                closing = 1'b1;
                if (slot_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result of the current request
    always_comb
    begin
        level_t settle;
        settle = LVL_PLENTY;
        for (int i = 0; i < 4; i++) settle = next_level(settle, cur_reg.sample_mv);

        if (closing)
        begin
            fv_new  = div_quot[SAMPLE_W-1:0];
            upd_new = 1'b1;
        end
        else if (!primed_reg)
        begin
            fv_new  = cur_reg.sample_mv;
            upd_new = 1'b1;
        end
        else
        begin
            fv_new  = fv_reg;
            upd_new = 1'b0;
        end
        level_base = primed_reg ? level_reg : settle;

        if (timer_reg == '0) timer_adv = '0;
        else if (timer_reg >= per_use) timer_adv = TIMER_W'(1);
        else timer_adv = timer_reg + 1'b1;

        fault_new = (fv_new <= MV_FAULT);
        alert_new = !fault_new && ((cur_reg.converter_duty > DUTY_W'(DUTY_ALERT)) ||
                                   (fv_new <= cur_reg.alert_threshold_mv));
        level_new = next_level(level_base, fv_new);

        strobe_new = 1'b0;
        if (level_new != LVL_VERYLOW) timer_next = '0;
        else if (timer_adv == '0) timer_next = TIMER_W'(1);
        else
        begin
            timer_next = timer_adv;
            strobe_new = (timer_adv < TIMER_W'(STROBE_ON_END));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            min_reg       <= MV_MIN_RESET;
            max_reg       <= '0;
            fv_reg        <= '0;
            level_reg     <= LVL_PLENTY;
            timer_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_ready) res_valid_reg <= 1'b0;
            if (finish)
            begin
                primed_reg    <= 1'b1;
                fv_reg        <= fv_new;
                level_reg     <= level_new;
                timer_reg     <= timer_next;
                res_valid_reg <= 1'b1;
                if (closing)
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    min_reg   <= MV_MIN_RESET;
                    max_reg   <= '0;
                end
                else if (primed_reg)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SUM_W'(cur_reg.sample_mv);
                    if (cur_reg.sample_mv < min_reg) min_reg <= cur_reg.sample_mv;
                    if (cur_reg.sample_mv > max_reg) max_reg <= cur_reg.sample_mv;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop) cur_reg <= item;
        if (finish)
        begin
            res_reg.filtered_mv <= fv_new;
            res_reg.level       <= level_new;
            res_reg.fault       <= fault_new;
            res_reg.alert       <= alert_new;
            res_reg.low_strobe  <= strobe_new;
            res_reg.updated     <= upd_new;
        end
    end

endmodule

// ===== sv/blm_checker.sv =====
// ----------------------------------------------------------------------------
// blm_checker
// Port-level checks of the battery level monitor result stream.
// ----------------------------------------------------------------------------
module blm_checker
    import blm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_fault_alert: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
        else $error("fault and alert both set");

    a_fault_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16] == (m_tdata[13:0] <= MV_FAULT)))
        else $error("fault does not match filtered voltage");

    a_strobe_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18] |-> (m_tdata[15:14] == LVL_VERYLOW))
        else $error("strobe outside very low level");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for battery_level_monitor. Cell voltage requests are
// streamed in with random gaps while results are drained with random stalls.
// Each accepted request runs through an in-bench model of the trimmed-mean
// window, level hysteresis, fault/alert flags and very-low strobe, and every
// result is compared field by field against the oldest predicted reading.
// Directed requests cover the field extremes, the first sample after reset,
// a window shrunk mid-fill and short strobe periods. Randomized phases then
// sweep window and strobe settings with drifting, plateau and noise voltages.
// ----------------------------------------------------------------------------
module tb;
    import blm_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int MAX_GAP         = 16;
    localparam int WINDOW_CAP      = 64;
    localparam int RESET_WINDOW    = 8;
    localparam int RESET_PERIOD    = 16;
    localparam int SAMPLE_MAX      = 16383;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 107;
    localparam int TAIL_CYCLES     = 40;
    localparam int LIMIT_CYCLES    = 500000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [0:0]             cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    logic [CFG_W-1:0]       win_setting;
    logic [CFG_W-1:0]       period_setting;
    logic [6:0]             win_count;
    logic [19:0]            win_sum;
    logic [SAMPLE_W-1:0]    win_lo;
    logic [SAMPLE_W-1:0]    win_hi;
    logic [SAMPLE_W-1:0]    filt_mv;
    level_t                 cur_level;
    logic [TIMER_W-1:0]     strobe_cnt;
    bit                     started;

    result_t pending_readings[$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      no_idle = 1'b0;
    int      nominal_mv = 3800;
    int      plateau_mv = 3700;
    int      chunk_left = 0;
    int      chunk_kind = 2;

    battery_level_monitor #(
        .MAX_WINDOW (WINDOW_CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic level_t level_after(input level_t lvl, input logic [SAMPLE_W-1:0] mv);
        case (lvl)
            LVL_PLENTY:  return (mv < MV_PLENTY_DOWN) ? LVL_MID : LVL_PLENTY;
            LVL_MID:     return (mv > MV_MID_UP) ? LVL_PLENTY :
                                (mv < MV_MID_DOWN) ? LVL_LOW : LVL_MID;
            LVL_LOW:     return (mv > MV_LOW_UP) ? LVL_MID :
                                (mv < MV_LOW_DOWN) ? LVL_VERYLOW : LVL_LOW;
            default:     return (mv > MV_VLOW_UP) ? LVL_LOW : LVL_VERYLOW;
        endcase
    endfunction

    task automatic restart_window();
        win_count = '0;
        win_sum   = '0;
        win_lo    = MV_MIN_RESET;
        win_hi    = '0;
    endtask

    task automatic predict_reading(input item_t it);
        logic [6:0]         win_eff;
        logic [TIMER_W-1:0] per_eff;
        logic [19:0]        trimmed;
        result_t            r;
        win_eff = (win_setting < WIN_MIN) ? 7'(WIN_MIN) :
                  (win_setting > WINDOW_CAP) ? 7'(WINDOW_CAP) : win_setting;
        per_eff = (period_setting < PERIOD_MIN) ? 7'(PERIOD_MIN) : period_setting;
        r = '0;
        if (!started)
        begin
            started = 1'b1;
            filt_mv = it.sample_mv;
            cur_level = LVL_PLENTY;
            repeat (4) cur_level = level_after(cur_level, it.sample_mv);
            r.updated = 1'b1;
        end
        else if (win_count < win_eff)
        begin
            win_count = win_count + 1'b1;
            win_sum = win_sum + it.sample_mv;
            if (it.sample_mv < win_lo) win_lo = it.sample_mv;
            if (it.sample_mv > win_hi) win_hi = it.sample_mv;
        end
        else
        begin
            trimmed = win_sum - win_lo - win_hi;
            filt_mv = 14'(trimmed / (win_count - 7'd2));
            restart_window();
            r.updated = 1'b1;
        end
        if (strobe_cnt != 0)
            strobe_cnt = (strobe_cnt >= per_eff) ? 7'd1 : strobe_cnt + 1'b1;
        r.fault = (filt_mv <= MV_FAULT);
        r.alert = !r.fault &&
                  ((it.converter_duty > DUTY_ALERT) || (filt_mv <= it.alert_threshold_mv));
        cur_level = level_after(cur_level, filt_mv);
        if (cur_level != LVL_VERYLOW)
            strobe_cnt = '0;
        else if (strobe_cnt == 0)
            strobe_cnt = 7'd1;
        else if (strobe_cnt < STROBE_ON_END)
            r.low_strobe = 1'b1;
        r.filtered_mv = filt_mv;
        r.level = cur_level;
        pending_readings.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    always @(posedge clk)
    begin : check_readings
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_readings.size() == 0)
                report_mismatch("result with no request pending");
            else
            begin
                want = pending_readings.pop_front();
                check_field("filtered_mv", got.filtered_mv, want.filtered_mv);
                check_field("level", int'(got.level), int'(want.level));
                check_field("fault", got.fault, want.fault);
                check_field("alert", got.alert, want.alert);
                check_field("low_strobe", got.low_strobe, want.low_strobe);
                check_field("updated", got.updated, want.updated);
            end
        end
    end

    initial
    begin : drive_ready
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] mv, input logic [SAMPLE_W-1:0] thr,
                               input logic [DUTY_W-1:0] duty);
        int    gap;
        item_t it;
        it.sample_mv = mv;
        it.alert_threshold_mv = thr;
        it.converter_duty = duty;
        @(negedge clk);
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(it);
        do @(posedge clk); while (!s_tready);
        predict_reading(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_WINDOW_SAMPLES)
            win_setting = value;
        else
            period_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_sample();
        int mv;
        int thr;
        int duty;
        int pick;
        if (chunk_left == 0)
        begin
            chunk_left = $urandom_range(1, 20);
            pick = $urandom_range(0, 9);
            chunk_kind = (pick == 0) ? 0 : (pick < 4) ? 1 : 2;
            case ($urandom_range(0, 5))
                0:       plateau_mv = MV_FAULT;
                1:       plateau_mv = MV_LOW_DOWN;
                2:       plateau_mv = MV_MID_DOWN;
                3:       plateau_mv = MV_LOW_UP;
                4:       plateau_mv = MV_PLENTY_DOWN;
                default: plateau_mv = MV_MID_UP;
            endcase
            plateau_mv = plateau_mv + $urandom_range(0, 2) - 1;
            nominal_mv = nominal_mv + $urandom_range(0, 300) - 150;
            if (nominal_mv < 2400) nominal_mv = 2400;
            if (nominal_mv > 4300) nominal_mv = 4300;
        end
        chunk_left--;
        case (chunk_kind)
            0:       mv = $urandom_range(0, SAMPLE_MAX);
            1:       mv = plateau_mv;
            default:
            begin
                mv = nominal_mv + $urandom_range(0, 120) - 60;
                if ($urandom_range(0, 15) == 0)
                    mv = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            end
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 2)
            thr = $urandom_range(0, SAMPLE_MAX);
        else if (pick < 5)
            thr = int'(filt_mv) + $urandom_range(0, 2) - 1;
        else
            thr = nominal_mv + $urandom_range(0, 600) - 300;
        if (thr < 0) thr = 0;
        if (thr > SAMPLE_MAX) thr = SAMPLE_MAX;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            duty = $urandom_range(0, 100);
        else if (pick < 17)
            duty = $urandom_range(74, 77);
        else
            duty = $urandom_range(0, 127);
        send_sample(14'(mv), 14'(thr), 7'(duty));
    endtask

    task automatic test_first_sample();
        send_sample(14'd2800, 14'd3000, 7'd10);
    endtask

    task automatic test_field_extremes();
        send_sample(14'd16383, 14'd0, 7'd0);
        send_sample(14'd0, 14'd16383, 7'd100);
        send_sample(14'd16383, 14'd16383, 7'd127);
        send_sample(14'd0, 14'd0, 7'd76);
        send_sample(14'd3700, 14'd2800, 7'd75);
        send_sample(14'd3900, 14'd3900, 7'd0);
        send_sample(14'd2700, 14'd2700, 7'd50);
        send_sample(14'd2900, 14'd16383, 7'd77);
        send_sample(14'd3200, 14'd0, 7'd127);
    endtask

    task automatic test_window_shrink();
        wait_idle();
        write_register(REG_WINDOW_SAMPLES, 7'd20);
        send_sample(14'd3000, 14'd3100, 7'd20);
        send_sample(14'd3300, 14'd3100, 7'd20);
        send_sample(14'd3600, 14'd3100, 7'd20);
        send_sample(14'd2600, 14'd3100, 7'd20);
        send_sample(14'd4000, 14'd3100, 7'd20);
        send_sample(14'd3400, 14'd3100, 7'd20);
        wait_idle();
        write_register(REG_WINDOW_SAMPLES, 7'd0);
        send_sample(14'd3500, 14'd3300, 7'd20);
        send_sample(14'd3500, 14'd3300, 7'd20);
    endtask

    task automatic test_short_strobe();
        wait_idle();
        write_register(REG_WINDOW_SAMPLES, 7'd3);
        write_register(REG_STROBE_PERIOD, 7'd0);
        repeat (7) send_sample(14'd2600, 14'd2000, 7'd30);
    endtask

    task automatic test_random_phases();
        int phase;
        int win;
        int per;
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin win = 3;   per = 4;   end
                1:       begin win = 5;   per = 0;   end
                2:       begin win = 127; per = 127; end
                3:       begin win = 64;  per = 3;   end
                4:       begin win = 1;   per = 1;   end
                5:
                begin
                    win = $urandom_range(3, 12);
                    per = $urandom_range(4, 40);
                end
                default:
                begin
                    win = $urandom_range(0, 127);
                    per = $urandom_range(0, 127);
                end
            endcase
            wait_idle();
            write_register(REG_WINDOW_SAMPLES, 7'(win));
            write_register(REG_STROBE_PERIOD, 7'(per));
            no_idle = (phase % 3 == 1);
            repeat (ITEMS_PER_PHASE) send_random_sample();
            no_idle = 1'b0;
        end
    endtask

    initial
    begin : run_tests
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_SAMPLES;
        cfg_data  = '0;
        win_setting    = 7'(RESET_WINDOW);
        period_setting = 7'(RESET_PERIOD);
        filt_mv    = '0;
        cur_level  = LVL_PLENTY;
        strobe_cnt = '0;
        started    = 1'b0;
        restart_window();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_first_sample();
        test_field_extremes();
        test_window_shrink();
        test_short_strobe();
        test_random_phases();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/blm_pkg.sv
sv/blm_queue.sv
sv/blm_div.sv
sv/blm_core.sv
sv/battery_level_monitor.sv
sv/blm_checker.sv
tb/tb.sv
